// ===== hdl/gsps_pkg.sv =====
package gsps_pkg;

    localparam int unsigned GRID_STEP_DEF = 7;
    localparam int unsigned STEP_W        = 8;

    localparam int unsigned IN_W    = 24;
    localparam int unsigned FRAC_W  = 8;
    localparam int unsigned TRUNC_W = 16;
    localparam int unsigned SNAP_W  = 17;
    localparam int unsigned OUT_W   = 16;

    localparam int unsigned RECIP_SHIFT = 24;

    localparam int unsigned MID_DEPTH = 8;
    localparam int unsigned MID_PTR_W = $clog2(MID_DEPTH);
    localparam int unsigned MID_CNT_W = $clog2(MID_DEPTH + 1);

    localparam int unsigned OUT_DEPTH = 4;
    localparam int unsigned OUT_PTR_W = $clog2(OUT_DEPTH);
    localparam int unsigned OUT_CNT_W = $clog2(OUT_DEPTH + 1);

    typedef struct packed {
        logic signed [SNAP_W-1:0] x;
        logic signed [SNAP_W-1:0] y;
        logic                     last;
    } t_vertex;

    typedef struct packed {
        logic             empty;
        logic [MID_CNT_W-1:0] cnt;
    } t_qstat;

endpackage

// ===== hdl/gsps_front.sv =====
module gsps_front #(
    parameter int unsigned GRID_STEP = gsps_pkg::GRID_STEP_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  logic signed [gsps_pkg::IN_W-1:0]    i_x,
    input  logic signed [gsps_pkg::IN_W-1:0]    i_y,
    input  logic                                i_last,
    input  gsps_pkg::t_qstat                    i_qstat,
    output logic                                o_full,
    output logic                                o_wr,
    output gsps_pkg::t_vertex                   o_vtx
);

    localparam int unsigned InW    = gsps_pkg::IN_W;
    localparam int unsigned FracW  = gsps_pkg::FRAC_W;
    localparam int unsigned TruncW = gsps_pkg::TRUNC_W;
    localparam int unsigned SnapW  = gsps_pkg::SNAP_W;
    localparam int unsigned StepW  = gsps_pkg::STEP_W;
    localparam int unsigned Shift  = gsps_pkg::RECIP_SHIFT;
    localparam int unsigned RecipW = Shift + 1;
    localparam int unsigned ProdW  = TruncW + RecipW;
    localparam int unsigned MulW   = TruncW + StepW;
    localparam int unsigned CntW   = gsps_pkg::MID_CNT_W;

    localparam logic [StepW-1:0]  Step  = StepW'(GRID_STEP);
    localparam logic [RecipW-1:0] Recip = RecipW'((64'd1 << Shift) / GRID_STEP);
    localparam logic [InW-1:0]    Half  = InW'((1 << (FracW - 1)) * GRID_STEP);

    // lane 0 is x, lane 1 is y
    logic signed [InW-1:0] s0_v   [2];
    logic [InW-1:0]        s0_mag [2];
    logic [InW-1:0]        s0_sum [2];
    logic                  accept;

    logic [TruncW-1:0] r1_t   [2];
    logic              r1_neg [2];
    logic              r1_last;
    logic              r1_v;

    logic [ProdW-1:0]  r2_prod [2];
    logic [TruncW-1:0] r2_t    [2];
    logic              r2_neg  [2];
    logic              r2_last;
    logic              r2_v;

    logic [TruncW-1:0] s2_q  [2];
    logic [MulW-1:0]   s2_qs [2];

    logic [TruncW-1:0] r3_qs  [2];
    logic [TruncW-1:0] r3_t   [2];
    logic              r3_neg [2];
    logic              r3_last;
    logic              r3_v;

    logic [TruncW-1:0]       s3_rem  [2];
    logic                    s3_corr [2];
    logic [SnapW-1:0]        s3_mag  [2];
    logic signed [SnapW-1:0] s3_snap [2];

    logic [CntW-1:0] inflight;

    // credit: queue entries plus beats still in the snap pipe never exceed the queue depth
    always_comb begin
        inflight = CntW'(r1_v) + CntW'(r2_v) + CntW'(r3_v);
        o_full   = (i_qstat.cnt + inflight) >= CntW'(gsps_pkg::MID_DEPTH);
        accept   = i_push && !o_full;
    end

    always_comb begin
        s0_v[0] = i_x;
        s0_v[1] = i_y;
        for (int l = 0; l < 2; l++) begin
            s0_mag[l] = s0_v[l][InW-1] ? InW'(-s0_v[l]) : InW'(s0_v[l]);
            s0_sum[l] = s0_mag[l] + Half;
        end
    end

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            s2_q[l]  = r2_prod[l][Shift +: TruncW];
            s2_qs[l] = MulW'(s2_q[l]) * MulW'(Step);
        end
    end

    // reciprocal estimate is at most one low: one compare fixes it
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            s3_rem[l]  = r3_t[l] - r3_qs[l];
            s3_corr[l] = s3_rem[l] >= TruncW'(Step);
            s3_mag[l]  = SnapW'(r3_qs[l]) + (s3_corr[l] ? SnapW'(Step) : '0);
            s3_snap[l] = r3_neg[l] ? SnapW'(-s3_mag[l]) : s3_mag[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
        end else begin
            r1_v <= accept;
            r2_v <= r1_v;
            r3_v <= r2_v;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int l = 0; l < 2; l++) begin
            r1_t[l]    <= s0_sum[l][InW-1:FracW];
            r1_neg[l]  <= s0_v[l][InW-1];
            r2_prod[l] <= ProdW'(r1_t[l]) * ProdW'(Recip);
            r2_t[l]    <= r1_t[l];
            r2_neg[l]  <= r1_neg[l];
            r3_qs[l]   <= s2_qs[l][TruncW-1:0];
            r3_t[l]    <= r2_t[l];
            r3_neg[l]  <= r2_neg[l];
        end
        r1_last <= i_last;
        r2_last <= r1_last;
        r3_last <= r2_last;
    end

    assign o_wr       = r3_v;
    assign o_vtx.x    = s3_snap[0];
    assign o_vtx.y    = s3_snap[1];
    assign o_vtx.last = r3_last;

endmodule

// ===== hdl/gsps_queue.sv =====
module gsps_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr,
    input  gsps_pkg::t_vertex i_vtx,
    input  logic              i_rd,
    output gsps_pkg::t_qstat  o_qstat,
    output gsps_pkg::t_vertex o_vtx
);

    localparam int unsigned Depth = gsps_pkg::MID_DEPTH;
    localparam int unsigned PtrW  = gsps_pkg::MID_PTR_W;
    localparam int unsigned CntW  = gsps_pkg::MID_CNT_W;

    gsps_pkg::t_vertex r_mem [Depth];
    logic [PtrW-1:0]   r_wptr;
    logic [PtrW-1:0]   r_rptr;
    logic [CntW-1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_vtx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= r_wptr + PtrW'(1);
            end
            if (i_rd) begin
                r_rptr <= r_rptr + PtrW'(1);
            end
            r_cnt <= r_cnt + CntW'(i_wr) - CntW'(i_rd);
        end
    end

    assign o_vtx         = r_mem[r_rptr];
    assign o_qstat.cnt   = r_cnt;
    assign o_qstat.empty = (r_cnt == '0);

    // the front's credit check must keep a full queue from being written
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_wr |-> (r_cnt < CntW'(Depth)))
        else $error("mid queue written while full");

endmodule

// ===== hdl/gsps_back.sv =====
module gsps_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  gsps_pkg::t_vertex                  i_vtx,
    output logic                               o_take,
    input  logic                               i_pop,
    output logic                               o_empty,
    output logic signed [gsps_pkg::OUT_W-1:0]  o_x,
    output logic signed [gsps_pkg::OUT_W-1:0]  o_y,
    output logic                               o_last
);

    localparam int unsigned SnapW = gsps_pkg::SNAP_W;
    localparam int unsigned OutW  = gsps_pkg::OUT_W;
    localparam int unsigned Depth = gsps_pkg::OUT_DEPTH;
    localparam int unsigned PtrW  = gsps_pkg::OUT_PTR_W;
    localparam int unsigned CntW  = gsps_pkg::OUT_CNT_W;

    localparam logic signed [SnapW-1:0] SatHi = SnapW'((1 << (OutW - 1)) - 1);
    localparam logic signed [SnapW-1:0] SatLo = -SatHi;

    typedef enum logic [2:0] {
        PH_IDLE = 3'b001,
        PH_KEPT = 3'b010,
        PH_PEND = 3'b100
    } t_phase;

    typedef struct packed {
        logic signed [OutW-1:0] x;
        logic signed [OutW-1:0] y;
        logic                   last;
    } t_result;

    function automatic logic signed [OutW-1:0] sat_out(input logic signed [SnapW-1:0] v);
        logic signed [SnapW-1:0] c;
        c = v;
        if (v > SatHi) begin
            c = SatHi;
        end else if (v < SatLo) begin
            c = SatLo;
        end
        return c[OutW-1:0];
    endfunction

    t_phase                  r_phase, n_phase;
    logic signed [SnapW-1:0] r_kept_x, n_kept_x;
    logic signed [SnapW-1:0] r_kept_y, n_kept_y;
    logic signed [SnapW-1:0] r_pend_x, n_pend_x;
    logic signed [SnapW-1:0] r_pend_y, n_pend_y;

    t_result         r_oq [Depth];
    logic [PtrW-1:0] r_wptr;
    logic [PtrW-1:0] r_rptr;
    logic [CntW-1:0] r_cnt;

    logic            drop;
    logic            emit_pend;
    logic            emit_cur;
    logic            cur_last;
    t_result         res_pend;
    t_result         res_cur;
    t_result         wr_first;
    logic [1:0]      n_push;
    logic            pop_ok;

    // two free slots cover the worst case of a pending vertex plus the final one
    assign o_take = i_valid && (r_cnt <= CntW'(Depth - 2));
    assign pop_ok = i_pop && !o_empty;

    always_comb begin
        n_phase   = r_phase;
        n_kept_x  = r_kept_x;
        n_kept_y  = r_kept_y;
        n_pend_x  = r_pend_x;
        n_pend_y  = r_pend_y;
        emit_pend = 1'b0;
        emit_cur  = 1'b0;
        cur_last  = i_vtx.last;
        drop      = ((r_kept_x == r_pend_x) && (i_vtx.x == r_pend_x)) ||
                    ((r_kept_y == r_pend_y) && (i_vtx.y == r_pend_y));
        if (o_take) begin
            unique case (r_phase)
                PH_KEPT: begin
                    if (i_vtx.last) begin
                        emit_cur = 1'b1;
                        n_phase  = PH_IDLE;
                    end else begin
                        n_pend_x = i_vtx.x;
                        n_pend_y = i_vtx.y;
                        n_phase  = PH_PEND;
                    end
                end
                PH_PEND: begin
                    if (!drop) begin
                        emit_pend = 1'b1;
                        n_kept_x  = r_pend_x;
                        n_kept_y  = r_pend_y;
                    end
                    if (i_vtx.last) begin
                        emit_cur = 1'b1;
                        n_phase  = PH_IDLE;
                    end else begin
                        n_pend_x = i_vtx.x;
                        n_pend_y = i_vtx.y;
                    end
                end
                default: begin
                    // idle, and any stray code, starts a new polyline
                    emit_cur = 1'b1;
                    if (i_vtx.last) begin
                        n_phase = PH_IDLE;
                    end else begin
                        n_kept_x = i_vtx.x;
                        n_kept_y = i_vtx.y;
                        n_phase  = PH_KEPT;
                    end
                end
            endcase
        end
    end

    always_comb begin
        res_pend.x    = sat_out(r_pend_x);
        res_pend.y    = sat_out(r_pend_y);
        res_pend.last = 1'b0;
        res_cur.x     = sat_out(i_vtx.x);
        res_cur.y     = sat_out(i_vtx.y);
        res_cur.last  = cur_last;
        wr_first      = emit_pend ? res_pend : res_cur;
        n_push        = 2'(emit_pend) + 2'(emit_cur);
    end

    always_ff @(posedge i_clk) begin
        if (n_push != 2'd0) begin
            r_oq[r_wptr] <= wr_first;
        end
        if (n_push == 2'd2) begin
            r_oq[r_wptr + PtrW'(1)] <= res_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_kept_x <= '0;
            r_kept_y <= '0;
            r_pend_x <= '0;
            r_pend_y <= '0;
            r_wptr   <= '0;
            r_rptr   <= '0;
            r_cnt    <= '0;
        end else begin
            r_phase  <= n_phase;
            r_kept_x <= n_kept_x;
            r_kept_y <= n_kept_y;
            r_pend_x <= n_pend_x;
            r_pend_y <= n_pend_y;
            r_wptr   <= r_wptr + PtrW'(n_push);
            if (pop_ok) begin
                r_rptr <= r_rptr + PtrW'(1);
            end
            r_cnt <= r_cnt + CntW'(n_push) - CntW'(pop_ok);
        end
    end

    assign o_empty = (r_cnt == '0);
    assign o_x     = r_oq[r_rptr].x;
    assign o_y     = r_oq[r_rptr].y;
    assign o_last  = r_oq[r_rptr].last;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CntW'(Depth))
        else $error("result queue count beyond depth");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && i_vtx.last) |=> (r_phase == PH_IDLE))
        else $error("end vertex did not close the polyline");

    a_first_emitted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_take && (r_phase == PH_IDLE)) |=> !o_empty)
        else $error("first vertex of a polyline not emitted");

endmodule

// ===== hdl/grid_snap_polyline_simplifier.sv =====
// Snaps polyline vertices (24-bit signed, 8 fraction bits) to the nearest multiple of
// GRID_STEP, rounding half away from zero, and drops a vertex that lines up in x or in y
// with both snapped neighbours; the first and last vertices always come out, the last with
// last_out set. One vertex is taken per cycle while full is low. A vertex passes through
// the snap pipeline (reciprocal multiply, multiply-back, one-step correction) and
// through the vertex queue and the simplifier before its result can show on the output
// side. A vertex yields zero, one or two beats, and the output side hands out one beat
// per cycle while popped, so a run of two-beat vertices (short polylines) is paced by
// the output port; the simplifier takes a vertex only while two output slots are free.
module grid_snap_polyline_simplifier #(
    parameter int unsigned GRID_STEP = gsps_pkg::GRID_STEP_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic signed [gsps_pkg::IN_W-1:0]   i_x_in,
    input  logic signed [gsps_pkg::IN_W-1:0]   i_y_in,
    input  logic                               i_last_in,
    output logic                               empty,
    input  logic                               pop,
    output logic signed [gsps_pkg::OUT_W-1:0]  o_x_out,
    output logic signed [gsps_pkg::OUT_W-1:0]  o_y_out,
    output logic                               o_last_out
);

    logic              fe_wr;
    gsps_pkg::t_vertex fe_vtx;
    gsps_pkg::t_qstat  q_stat;
    gsps_pkg::t_vertex q_vtx;
    logic              be_take;

    gsps_front #(
        .GRID_STEP (GRID_STEP)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_x     (i_x_in),
        .i_y     (i_y_in),
        .i_last  (i_last_in),
        .i_qstat (q_stat),
        .o_full  (full),
        .o_wr    (fe_wr),
        .o_vtx   (fe_vtx)
    );

    gsps_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (fe_wr),
        .i_vtx   (fe_vtx),
        .i_rd    (be_take),
        .o_qstat (q_stat),
        .o_vtx   (q_vtx)
    );

    gsps_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!q_stat.empty),
        .i_vtx   (q_vtx),
        .o_take  (be_take),
        .i_pop   (pop),
        .o_empty (empty),
        .o_x     (o_x_out),
        .o_y     (o_y_out),
        .o_last  (o_last_out)
    );

endmodule

// ===== test/gsps_vertex_checker.sv =====
`timescale 1ns / 1ps

module gsps_vertex_checker #(
    parameter int unsigned GRID_STEP = gsps_pkg::GRID_STEP_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  logic                               i_full,
    input  logic signed [gsps_pkg::IN_W-1:0]   i_x_in,
    input  logic signed [gsps_pkg::IN_W-1:0]   i_y_in,
    input  logic                               i_last_in,
    input  logic                               i_empty,
    input  logic                               i_pop,
    input  logic signed [gsps_pkg::OUT_W-1:0]  i_x_out,
    input  logic signed [gsps_pkg::OUT_W-1:0]  i_y_out,
    input  logic                               i_last_out,
    output int                                 o_fail_count,
    output int                                 o_due_count,
    output int                                 o_vertex_count,
    output int                                 o_beat_count,
    output int                                 o_drop_count
);

    localparam int unsigned InW   = gsps_pkg::IN_W;
    localparam int unsigned SnapW = gsps_pkg::SNAP_W;
    localparam int unsigned OutW  = gsps_pkg::OUT_W;

    typedef enum logic [2:0] {
        TRACE_IDLE     = 3'b001,
        TRACE_ANCHORED = 3'b010,
        TRACE_HOLDING  = 3'b100
    } t_trace_state;

    typedef struct {
        logic signed [OutW-1:0] x;
        logic signed [OutW-1:0] y;
        logic                   last;
    } t_snapped_beat;

    t_snapped_beat            due_beats[$];
    t_snapped_beat            want;
    t_trace_state             trace_state;
    logic signed [SnapW-1:0]  anchor_x, anchor_y;
    logic signed [SnapW-1:0]  held_x, held_y;

    // nearest multiple of the grid step in integer units, ties away from zero
    function automatic logic signed [SnapW-1:0] snap_coord(
        input logic signed [InW-1:0] raw);
        longint step;
        longint mag;
        longint units;
        step  = longint'(GRID_STEP);
        mag   = (raw < 0) ? -longint'(raw) : longint'(raw);
        units = (mag + 128 * step) / (256 * step) * step;
        return (raw < 0) ? SnapW'(-units) : SnapW'(units);
    endfunction

    function automatic logic signed [OutW-1:0] clamp_out(input logic signed [SnapW-1:0] v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32767)
            return -16'sd32767;
        return v[OutW-1:0];
    endfunction

    task automatic expect_beat(input logic signed [SnapW-1:0] x,
                               input logic signed [SnapW-1:0] y, input logic last);
        t_snapped_beat b;
        b.x    = clamp_out(x);
        b.y    = clamp_out(y);
        b.last = last;
        due_beats.push_back(b);
    endtask

    task automatic advance_trace(input logic signed [InW-1:0] raw_x,
                                 input logic signed [InW-1:0] raw_y, input logic last);
        logic signed [SnapW-1:0] sx;
        logic signed [SnapW-1:0] sy;
        logic                    redundant;
        sx = snap_coord(raw_x);
        sy = snap_coord(raw_y);
        unique case (trace_state)
            TRACE_ANCHORED: begin
                if (last) begin
                    expect_beat(sx, sy, 1'b1);
                    trace_state = TRACE_IDLE;
                end else begin
                    held_x      = sx;
                    held_y      = sy;
                    trace_state = TRACE_HOLDING;
                end
            end
            TRACE_HOLDING: begin
                // held vertex lies on a straight axis run through both neighbours
                redundant = (anchor_x == held_x && sx == held_x) ||
                            (anchor_y == held_y && sy == held_y);
                if (redundant) begin
                    o_drop_count++;
                end else begin
                    expect_beat(held_x, held_y, 1'b0);
                    anchor_x = held_x;
                    anchor_y = held_y;
                end
                if (last) begin
                    expect_beat(sx, sy, 1'b1);
                    trace_state = TRACE_IDLE;
                end else begin
                    held_x = sx;
                    held_y = sy;
                end
            end
            default: begin
                expect_beat(sx, sy, last);
                if (last) begin
                    trace_state = TRACE_IDLE;
                end else begin
                    anchor_x    = sx;
                    anchor_y    = sy;
                    trace_state = TRACE_ANCHORED;
                end
            end
        endcase
    endtask

    task automatic check_field(input string name, input int expected, input int actual);
        if (expected != actual) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, expected, actual);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            trace_state = TRACE_IDLE;
            anchor_x    = '0;
            anchor_y    = '0;
            held_x      = '0;
            held_y      = '0;
            due_beats.delete();
        end else begin
            if (i_pop && !i_empty) begin
                if (due_beats.size() == 0) begin
                    $display("%0t: beat with nothing expected, x_out=%0d y_out=%0d last_out=%0d",
                             $time, i_x_out, i_y_out, i_last_out);
                    o_fail_count++;
                end else begin
                    want = due_beats.pop_front();
                    o_beat_count++;
                    check_field("x_out", want.x, i_x_out);
                    check_field("y_out", want.y, i_y_out);
                    check_field("last_out", want.last, i_last_out);
                end
            end
            if (i_push && !i_full) begin
                o_vertex_count++;
                advance_trace(i_x_in, i_y_in, i_last_in);
            end
        end
        o_due_count = due_beats.size();
    end

endmodule

// ===== test/grid_snap_polyline_simplifier_tb.sv =====
`timescale 1ns / 1ps

module grid_snap_polyline_simplifier_tb;

    localparam int unsigned STEP = gsps_pkg::GRID_STEP_DEF;
    localparam int unsigned InW  = gsps_pkg::IN_W;
    localparam int unsigned OutW = gsps_pkg::OUT_W;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     push;
    logic                     full;
    logic signed [InW-1:0]    x_in;
    logic signed [InW-1:0]    y_in;
    logic                     last_in;
    logic                     empty;
    logic                     pop;
    logic signed [OutW-1:0]   x_out;
    logic signed [OutW-1:0]   y_out;
    logic                     last_out;

    int fail_count;
    int due_count;
    int vertex_count;
    int beat_count;
    int drop_count;
    int polyline_count;
    int sent_count;
    int tx_idle_pct;
    int rx_idle_pct;

    grid_snap_polyline_simplifier #(
        .GRID_STEP (STEP)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .push       (push),
        .full       (full),
        .i_x_in     (x_in),
        .i_y_in     (y_in),
        .i_last_in  (last_in),
        .empty      (empty),
        .pop        (pop),
        .o_x_out    (x_out),
        .o_y_out    (y_out),
        .o_last_out (last_out)
    );

    gsps_vertex_checker #(
        .GRID_STEP (STEP)
    ) u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_full         (full),
        .i_x_in         (x_in),
        .i_y_in         (y_in),
        .i_last_in      (last_in),
        .i_empty        (empty),
        .i_pop          (pop),
        .i_x_out        (x_out),
        .i_y_out        (y_out),
        .i_last_out     (last_out),
        .o_fail_count   (fail_count),
        .o_due_count    (due_count),
        .o_vertex_count (vertex_count),
        .o_beat_count   (beat_count),
        .o_drop_count   (drop_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // receiver stalls at random, and never pops while in reset
    always @(posedge i_clk) begin
        pop <= i_rst_n && ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // push is left high after a beat so back-to-back vertices need no extra edge
    task automatic send_vertex(input logic signed [InW-1:0] vx, input logic signed [InW-1:0] vy,
                               input logic vlast);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            push <= 1'b0;
            @(posedge i_clk);
        end
        push    <= 1'b1;
        x_in    <= vx;
        y_in    <= vy;
        last_in <= vlast;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        sent_count++;
        if (vlast)
            polyline_count++;
    endtask

    // hold the sender off until every expected beat has come out
    task automatic drain_results();
        push <= 1'b0;
        @(posedge i_clk);
        wait (due_count == 0);
        @(posedge i_clk);
    endtask

    // mostly axis-aligned walks so collinear vertices get dropped, plus some noise
    task automatic send_random_polyline();
        int                    len_pick;
        int                    len;
        int                    move;
        logic signed [InW-1:0] px;
        logic signed [InW-1:0] py;
        len_pick = $urandom_range(0, 99);
        if (len_pick < 10)
            len = 1;
        else if (len_pick < 20)
            len = 2;
        else if (len_pick < 85)
            len = $urandom_range(3, 8);
        else
            len = $urandom_range(9, 20);
        px = InW'($urandom());
        py = InW'($urandom());
        for (int i = 0; i < len; i++) begin
            move = $urandom_range(0, 99);
            if (move < 15) begin
                px = InW'($urandom());
                py = InW'($urandom());
            end else if (move < 55) begin
                px = InW'(px + int'($urandom_range(0, 120000)) - 60000);
                py = InW'(py + int'($urandom_range(0, 1200)) - 600);
            end else if (move < 90) begin
                px = InW'(px + int'($urandom_range(0, 1200)) - 600);
                py = InW'(py + int'($urandom_range(0, 120000)) - 60000);
            end else begin
                px = InW'(px + int'($urandom_range(0, 1200)) - 600);
                py = InW'(py + int'($urandom_range(0, 1200)) - 600);
            end
            send_vertex(px, py, i == len - 1);
        end
    endtask

    task automatic run_random_phase(input int vertices);
        int target;
        target = sent_count + vertices;
        while (sent_count < target)
            send_random_polyline();
    endtask

    initial begin
        push           <= 1'b0;
        x_in           <= '0;
        y_in           <= '0;
        last_in        <= 1'b0;
        i_rst_n        <= 1'b0;
        polyline_count = 0;
        sent_count     = 0;
        tx_idle_pct    = 15;
        rx_idle_pct    = 72;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // lone vertices
        send_vertex(0, 0, 1'b1);
        send_vertex(8388607, -8388608, 1'b1);
        // two-vertex polyline from an extreme corner
        send_vertex(-8388608, 8388607, 1'b0);
        send_vertex(896, -896, 1'b1);
        // ties round away from zero, just below a tie rounds toward zero
        send_vertex(895, -895, 1'b0);
        send_vertex(-897, 1791, 1'b0);
        send_vertex(2687, -2688, 1'b1);
        // middle vertex shares x with both neighbours
        send_vertex(0, 0, 1'b0);
        send_vertex(100, 5000, 1'b0);
        send_vertex(-100, 9000, 1'b1);
        // middle vertex shares y with both neighbours
        send_vertex(0, 0, 1'b0);
        send_vertex(5000, 600, 1'b0);
        send_vertex(9000, -600, 1'b0);
        send_vertex(9000, 20000, 1'b1);
        // right-angle corner is kept
        send_vertex(0, 0, 1'b0);
        send_vertex(0, 9000, 1'b0);
        send_vertex(9000, 9000, 1'b1);
        // square around the full range
        send_vertex(8388607, 8388607, 1'b0);
        send_vertex(-8388608, 8388607, 1'b0);
        send_vertex(-8388608, -8388608, 1'b0);
        send_vertex(8388607, -8388608, 1'b1);
        drain_results();

        run_random_phase(210);
        drain_results();

        tx_idle_pct = 72;
        rx_idle_pct = 15;
        run_random_phase(210);
        drain_results();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random_phase(200);

        push <= 1'b0;
        @(posedge i_clk);
        wait (due_count == 0);
        repeat (20) @(posedge i_clk);

        $display("covered %0d vertices in %0d polylines, %0d beats checked, %0d vertices dropped",
                 vertex_count, polyline_count, beat_count, drop_count);
        $display("idle mix sender/receiver 15/72, then 72/15, then none, drained between mixes");
        if (fail_count == 0 && due_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
hdl/gsps_pkg.sv
hdl/gsps_front.sv
hdl/gsps_queue.sv
hdl/gsps_back.sv
hdl/grid_snap_polyline_simplifier.sv
test/gsps_vertex_checker.sv
test/grid_snap_polyline_simplifier_tb.sv
